FILE: design/comment_language_tag_filter_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the comment language tag filter.
// Each macro expands to a concurrent assertion clocked on clk and disabled
// during rst, or to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef COMMENT_LANGUAGE_TAG_FILTER_DEFINES_SVH
`define COMMENT_LANGUAGE_TAG_FILTER_DEFINES_SVH
`ifndef SYNTH
// Property that holds at every clock edge.
`define CTF_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
// Property whose consequent holds in the cycle after the antecedent.
`define CTF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CTF_ASSERT(label, expr, msg)
`define CTF_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

FILE: design/ctf_pkg.sv
// ----------------------------------------------------------------------------
// ctf_pkg
// Types and constants shared by the comment language tag filter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ctf_pkg;

  // Configuration register indexes and reset values.
  localparam int                   CFG_IDX_W        = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_TAG   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_LEN   = 2'd1;
  localparam logic [63:0]          FILTER_TAG_RESET = 64'h0000_0000_0000_6E65;
  localparam logic [3:0]           FILTER_LEN_RESET = 4'd2;

  // Longest language tag that the filter register can hold.
  localparam int         TAG_CHARS = 8;
  localparam logic [3:0] TAG_LEN_MAX = 4'd8;

  // Characters the parser reacts to.
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_NL     = 8'h0A;

  typedef enum logic [1:0] {
    MODE_CODE  = 2'd0,
    MODE_BLOCK = 2'd1,
    MODE_LINE  = 2'd2
  } text_mode_t;

  typedef enum logic [1:0] {
    PH_NORMAL = 2'd0,
    PH_TAG    = 2'd1,
    PH_MATCH  = 2'd2,
    PH_REJECT = 2'd3
  } comment_phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FLUSH_RD,
    ST_FLUSH_WR,
    ST_TAIL_PREV,
    ST_TAIL_LAST
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic step;
    logic rd;
    logic push_ram;
    logic push_prev;
    logic push_last;
  } ctf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic can_push;
    logic step_flush;
    logic step_ram;
    logic flush_last;
  } ctf_stat_t;

endpackage

`default_nettype wire

FILE: design/ctf_ram.sv
// ----------------------------------------------------------------------------
// ctf_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ctf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 18
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire  [$clog2(DEPTH)-1:0] waddr,
  input  wire  [WIDTH-1:0]         wdata,
  input  wire                      re,
  input  wire  [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: design/ctf_ctrl.sv
// ----------------------------------------------------------------------------
// ctf_ctrl
// Controller: accepts source bytes and sequences the flush of the pending
// buffer, one emitted byte at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module ctf_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_stall,
  input  ctf_pkg::ctf_stat_t  stat,
  output ctf_pkg::ctf_cmd_t   cmd
);

  ctf_pkg::ctrl_state_t state;
  ctf_pkg::ctrl_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ctf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ctf_pkg::ST_IDLE: begin
        if (in_valid && stat.can_push && stat.step_flush) begin
          state_next = stat.step_ram ? ctf_pkg::ST_FLUSH_RD : ctf_pkg::ST_TAIL_PREV;
        end
      end
      ctf_pkg::ST_FLUSH_RD: begin
        state_next = ctf_pkg::ST_FLUSH_WR;
      end
      ctf_pkg::ST_FLUSH_WR: begin
        if (stat.can_push) begin
          state_next = stat.flush_last ? ctf_pkg::ST_TAIL_PREV : ctf_pkg::ST_FLUSH_RD;
        end
      end
      ctf_pkg::ST_TAIL_PREV: begin
        if (stat.can_push) begin
          state_next = ctf_pkg::ST_TAIL_LAST;
        end
      end
      ctf_pkg::ST_TAIL_LAST: begin
        if (stat.can_push) begin
          state_next = ctf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ctf_pkg::ST_IDLE;
      end
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      ctf_pkg::ST_IDLE: begin
        in_stall = !stat.can_push;
        cmd.step = in_valid && stat.can_push;
      end
      ctf_pkg::ST_FLUSH_RD: begin
        cmd.rd = 1'b1;
      end
      ctf_pkg::ST_FLUSH_WR: begin
        cmd.push_ram = stat.can_push;
      end
      ctf_pkg::ST_TAIL_PREV: begin
        cmd.push_prev = stat.can_push;
      end
      ctf_pkg::ST_TAIL_LAST: begin
        cmd.push_last = stat.can_push;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: design/ctf_dp.sv
// ----------------------------------------------------------------------------
// ctf_dp
// Datapath: configuration registers, comment parser state, pending buffer,
// tag compare and a two entry output queue.
// ----------------------------------------------------------------------------
`default_nettype none
`include "comment_language_tag_filter_defines.svh"

module ctf_dp #(
  parameter int PEND_DEPTH = 18
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  ctf_pkg::ctf_cmd_t                   cmd,
  output ctf_pkg::ctf_stat_t                  stat,
  input  wire  [7:0]                          in_byte,
  input  wire                                 cfg_we,
  input  wire  [ctf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [63:0]                         cfg_data,
  output logic                                out_valid,
  input  wire                                 out_stall,
  output logic [7:0]                          out_byte,
  output logic                                out_last
);

  localparam int IDX_W = $clog2(PEND_DEPTH);
  localparam int CNT_W = ($clog2(PEND_DEPTH + 1) > 4) ? $clog2(PEND_DEPTH + 1) : 4;
  localparam logic [CNT_W-1:0] CNT_FULL    = CNT_W'(PEND_DEPTH);
  localparam logic [CNT_W-1:0] CNT_MAX_TAG = CNT_W'(PEND_DEPTH - 2);
  localparam logic [CNT_W-1:0] CNT_TAG_REG = CNT_W'(ctf_pkg::TAG_CHARS);

  // Configuration registers.
  logic [63:0] filter_tag;
  logic [3:0]  filter_len;

  // Parser state.
  ctf_pkg::text_mode_t     mode, mode_next;
  ctf_pkg::comment_phase_t phase, phase_next;
  logic [CNT_W-1:0]        cnt, cnt_next;
  logic                    ovf, ovf_next;
  logic [63:0]             tag_chars, tag_chars_next;
  logic [7:0]              prevb, prevb_next;
  logic [7:0]              lastb, lastb_next;

  // Flush bookkeeping.
  logic [CNT_W-1:0] flush_num;
  logic [CNT_W-1:0] flush_idx;

  // Step decode.
  logic             full;
  logic [CNT_W-1:0] cnt_a;
  logic             ovf_a;
  logic [3:0]       flen;
  logic             tag_eq;
  logic             tag_match;
  logic             body;
  logic             do_flush;
  logic             emit_one;
  logic [7:0]       emit_b;
  logic             enter_tag;

  // Pending buffer memory.
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [7:0]       ram_rdata;

  // Output queue.
  logic       push;
  logic [7:0] push_b;
  logic       push_l;
  logic       pop;
  logic       head_v, tail_v;
  logic [7:0] head_b, tail_b;
  logic       head_l, tail_l;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_tag <= ctf_pkg::FILTER_TAG_RESET;
      filter_len <= ctf_pkg::FILTER_LEN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ctf_pkg::CFG_FILTER_TAG: filter_tag <= cfg_data;
        ctf_pkg::CFG_FILTER_LEN: filter_len <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Append of the new byte and the tag compare against the current register.
  always_comb begin
    full   = (cnt == CNT_FULL);
    cnt_a  = full ? CNT_FULL : cnt + CNT_W'(1);
    ovf_a  = ovf | full;
    flen   = (filter_len > ctf_pkg::TAG_LEN_MAX) ? ctf_pkg::TAG_LEN_MAX : filter_len;
    // The held tag characters must equal the register over the configured length.
    tag_eq = 1'b1;
    for (int i = 0; i < ctf_pkg::TAG_CHARS; i++) begin
      if ((4'(i) < flen) && (tag_chars[8*i +: 8] != filter_tag[8*i +: 8])) begin
        tag_eq = 1'b0;
      end
    end
    // Tag length is the old count; an overflowed tag never matches.
    tag_match = !ovf_a && (cnt <= CNT_MAX_TAG) && (cnt == CNT_W'(flen)) && tag_eq;
  end

  // Parser next state for one accepted byte.
  always_comb begin
    mode_next      = mode;
    phase_next     = phase;
    cnt_next       = cnt;
    ovf_next       = ovf;
    tag_chars_next = tag_chars;
    prevb_next     = prevb;
    lastb_next     = lastb;
    body           = 1'b0;
    do_flush       = 1'b0;
    emit_one       = 1'b0;
    emit_b         = lastb;
    enter_tag      = 1'b0;

    if (cnt == '0) begin
      // A single pending byte decides nothing yet.
      cnt_next   = CNT_W'(1);
      lastb_next = in_byte;
    end else begin
      prevb_next = lastb;
      lastb_next = in_byte;
      case (mode)
        ctf_pkg::MODE_BLOCK: begin
          if (lastb == ctf_pkg::CH_STAR && in_byte == ctf_pkg::CH_SLASH) begin
            do_flush  = 1'b1;
            mode_next = ctf_pkg::MODE_CODE;
          end else begin
            body = 1'b1;
          end
        end
        ctf_pkg::MODE_LINE: begin
          if (in_byte == ctf_pkg::CH_NL) begin
            do_flush  = 1'b1;
            mode_next = ctf_pkg::MODE_CODE;
          end else begin
            body = 1'b1;
          end
        end
        default: begin
          if (lastb == ctf_pkg::CH_SLASH && in_byte == ctf_pkg::CH_STAR) begin
            do_flush   = 1'b1;
            mode_next  = ctf_pkg::MODE_BLOCK;
            phase_next = ctf_pkg::PH_NORMAL;
          end else if (lastb == ctf_pkg::CH_SLASH && in_byte == ctf_pkg::CH_SLASH) begin
            do_flush   = 1'b1;
            mode_next  = ctf_pkg::MODE_LINE;
            phase_next = ctf_pkg::PH_NORMAL;
          end else begin
            emit_one = 1'b1;
            cnt_next = CNT_W'(1);
          end
        end
      endcase

      if (do_flush) begin
        cnt_next = '0;
        ovf_next = 1'b0;
      end

      // Comment body: tag sections and escaped percent signs.
      if (body) begin
        case (phase)
          ctf_pkg::PH_NORMAL: begin
            if (lastb == ctf_pkg::CH_PCT) begin
              if (in_byte != ctf_pkg::CH_PCT) begin
                phase_next          = ctf_pkg::PH_TAG;
                cnt_next            = CNT_W'(1);
                ovf_next            = 1'b0;
                tag_chars_next[7:0] = in_byte;
                enter_tag           = 1'b1;
              end else begin
                emit_one = 1'b1;
                emit_b   = ctf_pkg::CH_PCT;
                cnt_next = '0;
              end
            end else begin
              emit_one = 1'b1;
              cnt_next = CNT_W'(1);
            end
          end
          ctf_pkg::PH_TAG: begin
            if (in_byte == ctf_pkg::CH_LBRACE) begin
              phase_next = tag_match ? ctf_pkg::PH_MATCH : ctf_pkg::PH_REJECT;
              cnt_next   = '0;
              ovf_next   = 1'b0;
            end else begin
              cnt_next = cnt_a;
              ovf_next = ovf_a;
              // Only the first characters can ever match the register.
              if (cnt < CNT_TAG_REG) begin
                tag_chars_next[{cnt[2:0], 3'b000} +: 8] = in_byte;
              end
            end
          end
          ctf_pkg::PH_MATCH: begin
            emit_one = 1'b1;
            if (in_byte == ctf_pkg::CH_RBRACE) begin
              cnt_next   = '0;
              phase_next = ctf_pkg::PH_NORMAL;
            end else begin
              cnt_next = CNT_W'(1);
            end
          end
          default: begin
            if (in_byte == ctf_pkg::CH_RBRACE) begin
              cnt_next   = '0;
              phase_next = ctf_pkg::PH_NORMAL;
            end else begin
              cnt_next = CNT_W'(1);
            end
          end
        endcase
      end
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= ctf_pkg::MODE_CODE;
      phase     <= ctf_pkg::PH_NORMAL;
      cnt       <= '0;
      ovf       <= 1'b0;
      tag_chars <= '0;
    end else if (cmd.step) begin
      mode      <= mode_next;
      phase     <= phase_next;
      cnt       <= cnt_next;
      ovf       <= ovf_next;
      tag_chars <= tag_chars_next;
    end
  end

  // The newest two pending bytes are kept in registers for the delimiter tests.
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      prevb <= prevb_next;
      lastb <= lastb_next;
    end
  end

  // Flush counters: entries below count minus two come from the memory.
  always_ff @(posedge clk) begin
    if (rst) begin
      flush_num <= '0;
      flush_idx <= '0;
    end else if (cmd.step) begin
      flush_num <= cnt_a - CNT_W'(2);
      flush_idx <= '0;
    end else if (cmd.push_ram) begin
      flush_idx <= flush_idx + CNT_W'(1);
    end
  end

  // The first tag character moves to entry zero when a tag opens.
  assign ram_we    = cmd.step && !full;
  assign ram_waddr = enter_tag ? '0 : cnt[IDX_W-1:0];

  ctf_ram #(
    .WIDTH (8),
    .DEPTH (PEND_DEPTH)
  ) u_pend_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_byte),
    .re    (cmd.rd),
    .raddr (flush_idx[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // Status to the controller.
  always_comb begin
    stat.can_push   = !tail_v;
    stat.step_flush = do_flush;
    stat.step_ram   = (cnt_a > CNT_W'(2));
    stat.flush_last = (flush_idx + CNT_W'(1) == flush_num);
  end

  // Select the byte that enters the output queue.
  always_comb begin
    push   = (cmd.step && emit_one) || cmd.push_ram || cmd.push_prev || cmd.push_last;
    push_b = lastb;
    push_l = 1'b1;
    if (cmd.step) begin
      push_b = emit_b;
      push_l = 1'b1;
    end else if (cmd.push_ram) begin
      push_b = ram_rdata;
      push_l = 1'b0;
    end else if (cmd.push_prev) begin
      push_b = prevb;
      push_l = 1'b0;
    end
  end

  // Two entry output queue; the head drives the result port.
  assign pop = head_v && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_v <= 1'b0;
      tail_v <= 1'b0;
    end else if (pop) begin
      if (tail_v) begin
        head_b <= tail_b;
        head_l <= tail_l;
        if (push) begin
          tail_b <= push_b;
          tail_l <= push_l;
        end else begin
          tail_v <= 1'b0;
        end
      end else if (push) begin
        head_b <= push_b;
        head_l <= push_l;
      end else begin
        head_v <= 1'b0;
      end
    end else if (push) begin
      if (!head_v) begin
        head_v <= 1'b1;
        head_b <= push_b;
        head_l <= push_l;
      end else begin
        tail_v <= 1'b1;
        tail_b <= push_b;
        tail_l <= push_l;
      end
    end
  end

  assign out_valid = head_v;
  assign out_byte  = head_b;
  assign out_last  = head_l;

  // Checks on the parser and queue invariants.
  `CTF_ASSERT(a_cnt_range, cnt <= CNT_FULL, "pending count exceeds buffer depth")
  `CTF_ASSERT(a_queue_order, !tail_v || head_v, "queue tail valid while head is empty")
  `CTF_ASSERT(a_ovf_full, !ovf || (cnt == CNT_FULL), "tag overflow set with buffer not full")
  `CTF_ASSERT(a_cnt_tag, (cnt <= CNT_W'(1)) || ((mode != ctf_pkg::MODE_CODE) && (phase == ctf_pkg::PH_TAG)), "pending bytes grow outside a tag")
  `CTF_ASSERT_NEXT(a_flush_clear, cmd.step && do_flush, (cnt == '0) && !ovf, "flush left pending state")

endmodule

`default_nettype wire

FILE: design/comment_language_tag_filter.sv
// ----------------------------------------------------------------------------
// comment_language_tag_filter
// Throughput: one byte per cycle while the output queue has room and each byte
// emits at most one byte. Result bytes pass through a registered output queue.
// A comment delimiter with n pending bytes holds the input while the buffer
// flushes: each buffered byte takes a registered read of the pending RAM and a
// push, then the last two bytes come from registers.
// Reset (rst, synchronous): code mode, empty buffer, tag "en" of length 2.
// ----------------------------------------------------------------------------
`default_nettype none

module comment_language_tag_filter #(
  parameter int MAX_TAG = 16
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            in_valid,
  output logic                           in_stall,
  input  wire  [7:0]                     in_byte,
  output logic                           out_valid,
  input  wire                            out_stall,
  output logic [7:0]                     out_byte,
  output logic                           out_last,
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire  [ctf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [63:0]                    cfg_data
);

  localparam int PEND_DEPTH = MAX_TAG + 2;

  ctf_pkg::ctf_cmd_t  cmd;
  ctf_pkg::ctf_stat_t stat;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  ctf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  ctf_dp #(
    .PEND_DEPTH (PEND_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_byte   (in_byte),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule

`default_nettype wire

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb: regression for comment_language_tag_filter
// A behavioral copy of the filter runs alongside the RTL. It predicts the
// bytes that each accepted request produces and queues them in order. Every
// output byte, and its last flag, is checked against the oldest queued byte.
// The stimulus has a directed part, a back-pressure run and random C-like
// text. Both handshake sides idle at random, and the tag registers are
// changed between phases.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  localparam int      MAX_TAG     = 16;
  localparam int      PEND_DEPTH  = MAX_TAG + 2;
  localparam int      CLK_PERIOD  = 20;
  // Long enough for a full buffer to flush, with some margin.
  localparam int      TAIL_CYCLES = 2 * PEND_DEPTH + 24;
  localparam int      DRAIN_LIMIT = 20000;
  localparam int      HOLD_CYCLES = 80;
  localparam longint  RUN_LIMIT   = 64'd20_000_000;

  logic                          clk;
  logic                          rst;
  logic                          in_valid;
  logic                          in_stall;
  logic [7:0]                    in_byte;
  logic                          out_valid;
  logic                          out_stall;
  logic [7:0]                    out_byte;
  logic                          out_last;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [ctf_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [63:0]                   cfg_data;

  comment_language_tag_filter #(.MAX_TAG(MAX_TAG)) u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte (out_byte),
    .out_last (out_last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } out_char_t;

  // Expected output bytes, oldest first.
  out_char_t               filtered_q[$];
  out_char_t               want_char;

  // Shadow copy of the filter state and its registers.
  ctf_pkg::text_mode_t     cur_mode;
  ctf_pkg::comment_phase_t cur_phase;
  logic [7:0]              hold_buf [PEND_DEPTH];
  int unsigned             hold_cnt;
  bit                      hold_ovf;
  logic [63:0]             tag_reg;
  logic [3:0]              len_reg;
  logic [7:0]              step_out[$];

  // Stimulus control.
  logic [7:0]              frag[$];
  int unsigned             bytes_sent;
  int unsigned             mismatches;
  bit                      gaps_on;
  bit                      stall_on;
  bit                      hold_long;
  bit                      holding;

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Emits every held byte in order and empties the buffer.
  function automatic void flush_hold();
    for (int i = 0; i < hold_cnt; i++) step_out.push_back(hold_buf[i]);
    hold_cnt = 0;
    hold_ovf = 1'b0;
  endfunction

  // Keeps only the newest of the two held bytes.
  function automatic void keep_newest();
    hold_buf[0] = hold_buf[1];
    hold_cnt    = 1;
  endfunction

  // The held bytes, less the opening brace, must equal the configured tag.
  function automatic bit tag_hit();
    int unsigned want;
    int unsigned got;
    want = (len_reg > ctf_pkg::TAG_LEN_MAX) ? ctf_pkg::TAG_CHARS : len_reg;
    got  = hold_cnt - 1;
    if (hold_ovf || got > MAX_TAG || got != want) return 1'b0;
    for (int i = 0; i < got; i++) begin
      if (hold_buf[i] != tag_reg[8*i +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // One byte of comment text, interpreted by the section phase.
  function automatic void comment_char();
    case (cur_phase)
      ctf_pkg::PH_NORMAL: begin
        if (hold_buf[0] == ctf_pkg::CH_PCT) begin
          if (hold_buf[1] != ctf_pkg::CH_PCT) begin
            cur_phase = ctf_pkg::PH_TAG;
            keep_newest();
            hold_ovf = 1'b0;
          end else begin
            step_out.push_back(ctf_pkg::CH_PCT);
            hold_cnt = 0;
          end
        end else begin
          step_out.push_back(hold_buf[0]);
          keep_newest();
        end
      end
      ctf_pkg::PH_TAG: begin
        if (hold_buf[hold_cnt-1] == ctf_pkg::CH_LBRACE) begin
          cur_phase = tag_hit() ? ctf_pkg::PH_MATCH : ctf_pkg::PH_REJECT;
          hold_cnt  = 0;
          hold_ovf  = 1'b0;
        end
      end
      default: begin
        // Matched sections pass their body; rejected ones drop it.
        if (cur_phase == ctf_pkg::PH_MATCH) step_out.push_back(hold_buf[0]);
        if (hold_buf[1] == ctf_pkg::CH_RBRACE) begin
          hold_cnt  = 0;
          cur_phase = ctf_pkg::PH_NORMAL;
        end else begin
          keep_newest();
        end
      end
    endcase
  endfunction

  // Works out the bytes that one accepted request produces and queues them.
  function automatic void filter_char(input logic [7:0] b);
    out_char_t e;
    step_out.delete();
    if (hold_cnt < PEND_DEPTH) begin
      hold_buf[hold_cnt] = b;
      hold_cnt++;
    end else begin
      // Full buffer: the last two bytes stay exact, the tag is spoiled.
      hold_ovf = 1'b1;
      hold_buf[PEND_DEPTH-2] = hold_buf[PEND_DEPTH-1];
      hold_buf[PEND_DEPTH-1] = b;
    end
    if (hold_cnt > 1) begin
      case (cur_mode)
        ctf_pkg::MODE_BLOCK: begin
          if (hold_buf[hold_cnt-2] == ctf_pkg::CH_STAR &&
              hold_buf[hold_cnt-1] == ctf_pkg::CH_SLASH) begin
            flush_hold();
            cur_mode = ctf_pkg::MODE_CODE;
          end else begin
            comment_char();
          end
        end
        ctf_pkg::MODE_LINE: begin
          if (hold_buf[hold_cnt-1] == ctf_pkg::CH_NL) begin
            flush_hold();
            cur_mode = ctf_pkg::MODE_CODE;
          end else begin
            comment_char();
          end
        end
        default: begin
          if (hold_buf[0] == ctf_pkg::CH_SLASH && hold_buf[1] == ctf_pkg::CH_STAR) begin
            flush_hold();
            cur_mode  = ctf_pkg::MODE_BLOCK;
            cur_phase = ctf_pkg::PH_NORMAL;
          end else if (hold_buf[0] == ctf_pkg::CH_SLASH &&
                       hold_buf[1] == ctf_pkg::CH_SLASH) begin
            flush_hold();
            cur_mode  = ctf_pkg::MODE_LINE;
            cur_phase = ctf_pkg::PH_NORMAL;
          end else begin
            step_out.push_back(hold_buf[0]);
            keep_newest();
          end
        end
      endcase
    end
    foreach (step_out[i]) begin
      e.ch   = step_out[i];
      e.last = (i == step_out.size() - 1);
      filtered_q.push_back(e);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) $display("%0t: mismatch: %s", $time, msg);
  endtask

  // Each accepted output byte is compared with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (filtered_q.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %h last %b", out_byte, out_last));
      end else begin
        want_char = filtered_q.pop_front();
        if (out_byte !== want_char.ch)
          report_mismatch($sformatf("out_byte %h, expected %h", out_byte, want_char.ch));
        if (out_last !== want_char.last)
          report_mismatch($sformatf("out_last %b on byte %h, expected %b",
                                    out_last, out_byte, want_char.last));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driving
  // --------------------------------------------------------------------------

  // Mostly short idle stretches, now and then a long one.
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(6, 25);
    return $urandom_range(1, 2);
  endfunction

  // Receiver: random stalls, or one long hold-off when a test asks for it.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_long) begin
        holding = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_long = 1'b0;
        holding   = 1'b0;
      end else if (stall_on && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat (pick_gap()) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Offers one source byte and waits for the request to be taken.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (in_stall);
    filter_char(b);
    bytes_sent++;
    gap = (gaps_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_frag();
    foreach (frag[i]) send_byte(frag[i]);
  endtask

  // Waits until every expected byte is out, then lets a flush run out.
  task automatic wait_idle();
    int unsigned waited;
    in_valid <= 1'b0;
    waited = 0;
    while (filtered_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (filtered_q.size() != 0) begin
      report_mismatch($sformatf("%0d expected bytes never came out", filtered_q.size()));
      filtered_q.delete();
    end
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Writes the tag and then the length register; only called while idle.
  task automatic set_filter(input logic [63:0] tag, input logic [63:0] len_word);
    cfg_valid <= 1'b1;
    cfg_index <= ctf_pkg::CFG_FILTER_TAG;
    cfg_data  <= tag;
    do @(posedge clk); while (!cfg_ready);
    tag_reg = tag;
    cfg_index <= ctf_pkg::CFG_FILTER_LEN;
    cfg_data  <= len_word;
    do @(posedge clk); while (!cfg_ready);
    len_reg = len_word[3:0];
    cfg_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Random text
  // --------------------------------------------------------------------------

  // Any byte that the parser does not react to.
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == ctf_pkg::CH_SLASH || c == ctf_pkg::CH_STAR || c == ctf_pkg::CH_PCT ||
           c == ctf_pkg::CH_LBRACE || c == ctf_pkg::CH_RBRACE || c == ctf_pkg::CH_NL);
    return c;
  endfunction

  function automatic void add_plain(input int unsigned n);
    repeat (n) frag.push_back(plain_char());
  endfunction

  function automatic logic [7:0] noise_char();
    case ($urandom_range(0, 7))
      0:       return ctf_pkg::CH_SLASH;
      1:       return ctf_pkg::CH_STAR;
      2:       return ctf_pkg::CH_PCT;
      3:       return ctf_pkg::CH_LBRACE;
      4:       return ctf_pkg::CH_RBRACE;
      5:       return ctf_pkg::CH_NL;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [63:0] rand_letters();
    logic [63:0] t;
    for (int i = 0; i < ctf_pkg::TAG_CHARS; i++) begin
      t[8*i +: 8] = 8'h61 + 8'($urandom_range(0, 25));
    end
    return t;
  endfunction

  // One piece of comment body: text, a doubled percent or a tag section.
  function automatic void add_piece();
    int unsigned want;
    want = (len_reg > ctf_pkg::TAG_LEN_MAX) ? ctf_pkg::TAG_CHARS : len_reg;
    case ($urandom_range(0, 9))
      0, 1, 2: add_plain($urandom_range(1, 5));
      3: begin
        frag.push_back(ctf_pkg::CH_PCT);
        frag.push_back(ctf_pkg::CH_PCT);
      end
      4, 5, 6: begin
        frag.push_back(ctf_pkg::CH_PCT);
        for (int i = 0; i < want; i++) frag.push_back(tag_reg[8*i +: 8]);
        frag.push_back(ctf_pkg::CH_LBRACE);
        add_plain($urandom_range(0, 4));
        frag.push_back(ctf_pkg::CH_RBRACE);
      end
      7, 8: begin
        // A foreign tag, sometimes too long for the buffer.
        frag.push_back(ctf_pkg::CH_PCT);
        add_plain(($urandom_range(0, 2) == 0) ? $urandom_range(17, 22) : $urandom_range(1, 6));
        frag.push_back(ctf_pkg::CH_LBRACE);
        add_plain($urandom_range(0, 4));
        frag.push_back(ctf_pkg::CH_RBRACE);
      end
      default: begin
        // Section left open, so the comment may close inside it.
        frag.push_back(ctf_pkg::CH_PCT);
        add_plain($urandom_range(0, 3));
      end
    endcase
  endfunction

  function automatic void build_fragment();
    frag.delete();
    case ($urandom_range(0, 9))
      0, 1: add_plain($urandom_range(1, 6));
      2, 3, 4, 5: begin
        frag.push_back(ctf_pkg::CH_SLASH);
        frag.push_back(ctf_pkg::CH_STAR);
        repeat ($urandom_range(1, 4)) add_piece();
        frag.push_back(ctf_pkg::CH_STAR);
        frag.push_back(ctf_pkg::CH_SLASH);
      end
      6, 7: begin
        frag.push_back(ctf_pkg::CH_SLASH);
        frag.push_back(ctf_pkg::CH_SLASH);
        repeat ($urandom_range(1, 4)) add_piece();
        frag.push_back(ctf_pkg::CH_NL);
      end
      default: repeat ($urandom_range(1, 8)) frag.push_back(noise_char());
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Code text, the byte extremes and near-miss delimiters pass unchanged.
  task automatic test_code_passthrough();
    gaps_on  = 1'b0;
    stall_on = 1'b0;
    send_byte(8'h00);
    send_byte(8'hFF);
    send_text("a/b%{}*x");
    wait_idle();
  endtask

  // Block and line comments with matching, foreign and empty tags.
  task automatic test_comment_sections();
    gaps_on  = 1'b1;
    stall_on = 1'b1;
    send_text("/*a%en{Hi}%fr{No}%%*/");
    send_text("//%e{x}%en{y}%{z}\n");
    wait_idle();
  endtask

  // Buffer overflow, zero bytes in a flush, and comments closing mid-section.
  task automatic test_tag_limits();
    send_text("/*%");
    repeat (20) send_byte("q");
    send_text("{Z}b*/");
    // An overflowed tag that the comment close cuts off flushes the whole buffer.
    send_text("/*%");
    repeat (20) send_byte("r");
    send_text("*/");
    send_text("/*%");
    send_byte(8'h00);
    send_byte(8'h00);
    send_text("*/");
    // The phase survives the close until the next comment opens.
    send_text("/*%en{cut*/k/*w*/");
    send_text("//%en\n");
    wait_idle();
  endtask

  // Register extremes: zero and all-ones tags, lengths zero, eight and above.
  task automatic test_filter_settings();
    set_filter(64'h0, 64'd8);
    send_text("/*%");
    repeat (8) send_byte(8'h00);
    send_text("{k}*/");
    wait_idle();
    set_filter('1, '1);
    send_text("/*%");
    repeat (8) send_byte(8'hFF);
    send_text("{o}*/");
    wait_idle();
    set_filter(64'h6867_6665_6463_6261, 64'd8);
    send_text("//%abcdefgh{m}%abcdefg{n}\n");
    wait_idle();
    set_filter(64'h0123_4567_89AB_CDEF, 64'hFFFF_FFFF_FFFF_FFF0);
    send_text("//%{e}%ab{f}\n");
    wait_idle();
  endtask

  // The receiver holds off while the sender keeps offering requests.
  task automatic test_backpressure();
    set_filter(ctf_pkg::FILTER_TAG_RESET, 64'(ctf_pkg::FILTER_LEN_RESET));
    gaps_on   = 1'b0;
    hold_long = 1'b1;
    while (!holding) @(posedge clk);
    for (int i = 0; i < 20; i++) send_byte(8'h41 + 8'(i));
    send_text("/*%");
    repeat (18) send_byte("s");
    send_text("*/");
    wait_idle();
  endtask

  // Mostly well-formed comments with random content, some noise.
  task automatic test_random_text();
    int unsigned goal;
    logic [63:0] tag;
    logic [63:0] len_word;
    for (int ph = 0; ph < 2; ph++) begin
      wait_idle();
      tag      = rand_letters();
      len_word = {$urandom, $urandom};
      len_word[3:0] = 4'($urandom_range(0, 9));
      case ($urandom_range(0, 4))
        0: begin
          tag      = ctf_pkg::FILTER_TAG_RESET;
          len_word = 64'(ctf_pkg::FILTER_LEN_RESET);
        end
        1: tag = 64'h0;
        2: tag = '1;
        default: ;
      endcase
      set_filter(tag, len_word);
      goal = bytes_sent + 10;
      while (bytes_sent < goal) begin
        gaps_on  = ($urandom_range(0, 3) != 0);
        stall_on = ($urandom_range(0, 3) != 0);
        build_fragment();
        send_frag();
      end
    end
    // Text ending inside an open tag: the held bytes never come out.
    send_text("/*%tail");
    wait_idle();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_byte    = 8'h00;
    cfg_valid  = 1'b0;
    cfg_index  = ctf_pkg::CFG_FILTER_TAG;
    cfg_data   = 64'h0;
    gaps_on    = 1'b0;
    stall_on   = 1'b0;
    hold_long  = 1'b0;
    holding    = 1'b0;
    bytes_sent = 0;
    mismatches = 0;
    cur_mode   = ctf_pkg::MODE_CODE;
    cur_phase  = ctf_pkg::PH_NORMAL;
    hold_cnt   = 0;
    hold_ovf   = 1'b0;
    tag_reg    = ctf_pkg::FILTER_TAG_RESET;
    len_reg    = ctf_pkg::FILTER_LEN_RESET;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_code_passthrough();
    test_comment_sections();
    test_tag_limits();
    test_filter_settings();
    test_backpressure();
    test_random_text();

    if (mismatches == 0) begin
      $display("comment_language_tag_filter regression: pass");
    end else begin
      $display("comment_language_tag_filter regression: fail");
    end
    $finish;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #(RUN_LIMIT);
    $display("comment_language_tag_filter regression: fail");
    $finish;
  end

endmodule

`default_nettype wire
